### rtl/core/edc_pkg.sv
// ----------------------------------------------------------------------------
// edc_pkg - shared definitions for the edit distance engine
// Command codes, field widths, default word capacity and cell control type.
// ----------------------------------------------------------------------------
`default_nettype none

package edc_pkg;

  // default capacity of each word store, in characters
  localparam int unsigned MAX_LEN_DEF = 64;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned DIST_W = 7;

  localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd2;

  // per-cell control handed to the min unit
  typedef struct packed {
    logic mismatch;   // characters differ, substitution costs one
    logic trans_ok;   // adjacent swap candidate is legal for this cell
  } edc_cell_ctl_t;

endpackage

`default_nettype wire

### rtl/core/edc_cell.sv
// ----------------------------------------------------------------------------
// edc_cell - edit distance cell unit
// Min over delete, insert, substitute and optional swap for one table cell.
// ----------------------------------------------------------------------------
`default_nettype none

module edc_cell #(
  parameter int unsigned VW = 7
) (
  input  edc_pkg::edc_cell_ctl_t ctl,
  input  logic [VW-1:0]          up,     // previous row, same column
  input  logic [VW-1:0]          diag,   // previous row, column - 1
  input  logic [VW-1:0]          left,   // current row, column - 1
  input  logic [VW-1:0]          diag2,  // row - 2, column - 2
  output logic [VW-1:0]          cost
);

  logic [VW:0] one_c;
  logic [VW:0] del_c;
  logic [VW:0] ins_c;
  logic [VW:0] sub_c;
  logic [VW:0] swp_c;
  logic [VW:0] min_a;
  logic [VW:0] min_b;
  logic [VW:0] min_c;

  assign one_c = {{VW{1'b0}}, 1'b1};
  assign del_c = {1'b0, up} + one_c;
  assign ins_c = {1'b0, left} + one_c;
  assign sub_c = {1'b0, diag} + {{VW{1'b0}}, ctl.mismatch};
  assign swp_c = {1'b0, diag2} + one_c;

  assign min_a = (del_c < ins_c) ? del_c : ins_c;
  assign min_b = (sub_c < min_a) ? sub_c : min_a;
  assign min_c = (ctl.trans_ok && (swp_c < min_b)) ? swp_c : min_b;

  // result never exceeds the longer word, so the top bit is always clear
  assign cost = min_c[VW-1:0];

endmodule

`default_nettype wire

### rtl/core/edit_distance_engine.sv
// ----------------------------------------------------------------------------
// edit_distance_engine - Levenshtein / optimal string alignment distance
// Loads two byte words one character per handshake, then walks the DP table one
// cell per cycle through a single shared min unit and returns the distance.
// ----------------------------------------------------------------------------
// Load words (first/second): accepted while idle, and the input stays ready.
// Compute word: ST_INIT writes row zero, ST_ROW walks the table rows, ST_DONE
//   fills the output register; one cell per cycle through the shared min unit.
// Input is not ready while a compute runs; a result may wait in the output
//   register while new characters load.
// Reset (rst_n low, synchronous) clears lengths, overflow, mode and control;
//   the word and row stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module edit_distance_engine #(
  parameter int unsigned MAX_LEN = edc_pkg::MAX_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_value
  input  wire logic [1:0]  in_tuser,   // [1:0] cmd

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [6:0] distance, [7] zero
  output logic [0:0]       out_tuser,  // [0] overflow

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_data    // [0] transposition_mode
);

  // value/length width, issue counter width, word store address width
  localparam int unsigned CW   = $clog2(MAX_LEN + 1);
  localparam int unsigned KW   = $clog2(MAX_LEN + 2);
  localparam int unsigned AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned ROWS = MAX_LEN + 1;
  localparam int unsigned DW   = edc_pkg::DIST_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;  // write row zero: prev[k] = k
  localparam logic [1:0] ST_ROW  = 2'd2;  // one table row, one cell a cycle
  localparam logic [1:0] ST_DONE = 2'd3;  // hand result to output register

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  logic [1:0]    st_r,      st_nxt;
  logic [KW-1:0] k_r,       k_nxt;       // issue column
  logic          arr_v_r,   arr_v_nxt;   // read data for arr_k_r is present
  logic [CW-1:0] arr_k_r,   arr_k_nxt;   // column whose read data is present
  logic [CW-1:0] i_r,       i_nxt;       // current row, 1..n1
  logic [1:0]    rot_r,     rot_nxt;     // which row memory holds "current"
  logic [CW-1:0] len1_r,    len1_nxt;
  logic [CW-1:0] len2_r,    len2_nxt;
  logic          ovf_r,     ovf_nxt;
  logic          mode_r,    mode_nxt;
  logic          out_vld_r, out_vld_nxt;

  // payload registers
  logic [CW-1:0]         last_r,  last_nxt;   // last cell value written
  logic [CW-1:0]         left_r,  left_nxt;   // cur[k-1]
  logic [CW-1:0]         pm1_r,   pm1_nxt;    // prev[k-1]
  logic [CW-1:0]         bp1_r,   bp1_nxt;    // bprev[k-1]
  logic [CW-1:0]         bp2_r,   bp2_nxt;    // bprev[k-2]
  logic [7:0]            bprv_r,  bprv_nxt;   // second[k-2]
  logic [7:0]            aprv_r,  aprv_nxt;   // first[i-2]
  logic [DW-1:0]         odist_r, odist_nxt;
  logic                  oovf_r,  oovf_nxt;

  // --------------------------------------------------------------------------
  // stores
  // --------------------------------------------------------------------------
  logic [7:0]    first_mem  [MAX_LEN];
  logic [7:0]    second_mem [MAX_LEN];
  logic [7:0]    first_rd;
  logic [7:0]    second_rd;
  logic [AW-1:0] first_ra;
  logic [AW-1:0] second_ra;
  logic          first_we;
  logic          second_we;

  logic [CW-1:0] row_rd [3];
  logic          row_we;
  logic [1:0]    row_wrole;
  logic [CW-1:0] row_wa;
  logic [CW-1:0] row_wd;
  logic [CW-1:0] row_ra;

  logic [1:0]    prev_role;
  logic [1:0]    bprev_role;
  logic [CW-1:0] prev_q;
  logic [CW-1:0] bprev_q;

  logic [KW-1:0] k_m1;
  logic [CW-1:0] i_m1;

  logic                  in_acc;
  logic [1:0]            cmd;
  logic [7:0]            char_in;
  logic                  issue;
  logic                  row_end;
  logic                  out_free;
  edc_pkg::edc_cell_ctl_t cell_ctl;
  logic [CW-1:0]         cell_cost;
  logic [CW+DW-1:0]      dist_ext;

  assign cmd     = in_tuser;
  assign char_in = in_tdata;
  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_vld_r || out_tready;

  assign k_m1      = k_r - {{(KW-1){1'b0}}, 1'b1};
  assign i_m1      = i_r - {{(CW-1){1'b0}}, 1'b1};
  assign first_ra  = i_m1[AW-1:0];
  assign second_ra = k_m1[AW-1:0];
  assign row_ra    = k_r[CW-1:0];

  assign first_we  = in_acc && (cmd == edc_pkg::CMD_LOAD_FIRST)
                     && (len1_r < CW'(MAX_LEN));
  assign second_we = in_acc && (cmd == edc_pkg::CMD_LOAD_SECOND)
                     && (len2_r < CW'(MAX_LEN));

  always_ff @(posedge clk) begin
    if (first_we) begin
      first_mem[len1_r[AW-1:0]] <= char_in;
    end
    if (second_we) begin
      second_mem[len2_r[AW-1:0]] <= char_in;
    end
    first_rd  <= first_mem[first_ra];
    second_rd <= second_mem[second_ra];
  end

  // three rotating row memories: current, previous, before previous
  for (genvar m = 0; m < 3; m++) begin : g_row
    logic [CW-1:0] mem [ROWS];
    always_ff @(posedge clk) begin
      if (row_we && (row_wrole == 2'(m))) begin
        mem[row_wa] <= row_wd;
      end
      row_rd[m] <= mem[row_ra];
    end
  end

  always_comb begin
    case (rot_r)
      2'd0: begin
        prev_role  = 2'd1;
        bprev_role = 2'd2;
      end
      2'd1: begin
        prev_role  = 2'd2;
        bprev_role = 2'd0;
      end
      default: begin
        prev_role  = 2'd0;
        bprev_role = 2'd1;
      end
    endcase
  end

  assign prev_q  = row_rd[prev_role];
  assign bprev_q = row_rd[bprev_role];

  // --------------------------------------------------------------------------
  // shared cell unit
  // --------------------------------------------------------------------------
  assign cell_ctl.mismatch = (first_rd != second_rd);
  assign cell_ctl.trans_ok = mode_r && (i_r > CW'(1)) && (arr_k_r > CW'(1))
                             && (first_rd == bprv_r) && (aprv_r == second_rd);

  edc_cell #(
    .VW (CW)
  ) u_cell (
    .ctl   (cell_ctl),
    .up    (prev_q),
    .diag  (pm1_r),
    .left  (left_r),
    .diag2 (bp2_r),
    .cost  (cell_cost)
  );

  assign issue   = (st_r == ST_ROW) && (k_r <= KW'(len2_r));
  assign row_end = (st_r == ST_ROW) && arr_v_r && (arr_k_r == len2_r);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    st_nxt      = st_r;
    k_nxt       = k_r;
    arr_v_nxt   = 1'b0;
    arr_k_nxt   = arr_k_r;
    i_nxt       = i_r;
    rot_nxt     = rot_r;
    len1_nxt    = len1_r;
    len2_nxt    = len2_r;
    ovf_nxt     = ovf_r;
    mode_nxt    = mode_r;
    out_vld_nxt = out_vld_r && !out_tready;
    last_nxt    = last_r;
    left_nxt    = left_r;
    pm1_nxt     = pm1_r;
    bp1_nxt     = bp1_r;
    bp2_nxt     = bp2_r;
    bprv_nxt    = bprv_r;
    aprv_nxt    = aprv_r;
    odist_nxt   = odist_r;
    oovf_nxt    = oovf_r;
    row_we      = 1'b0;
    row_wrole   = rot_r;
    row_wa      = arr_k_r;
    row_wd      = cell_cost;
    dist_ext    = {{DW{1'b0}}, last_r};

    if (cfg_valid) begin
      mode_nxt = cfg_data[0];
    end

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            edc_pkg::CMD_LOAD_FIRST: begin
              if (first_we) begin
                len1_nxt = len1_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            edc_pkg::CMD_LOAD_SECOND: begin
              if (second_we) begin
                len2_nxt = len2_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            edc_pkg::CMD_COMPUTE: begin
              st_nxt = ST_INIT;
              k_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_INIT: begin
        row_we    = 1'b1;
        row_wrole = prev_role;
        row_wa    = k_r[CW-1:0];
        row_wd    = k_r[CW-1:0];
        last_nxt  = k_r[CW-1:0];
        if (k_r == KW'(len2_r)) begin
          k_nxt = '0;
          i_nxt = CW'(1);
          if (len1_r == '0) begin
            st_nxt = ST_DONE;
          end else begin
            st_nxt = ST_ROW;
          end
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end

      ST_ROW: begin
        if (issue) begin
          k_nxt     = k_r + KW'(1);
          arr_v_nxt = 1'b1;
          arr_k_nxt = k_r[CW-1:0];
        end
        // column zero of the current row holds the row number
        if (k_r == '0) begin
          row_we   = 1'b1;
          row_wa   = '0;
          row_wd   = i_r;
          last_nxt = i_r;
          left_nxt = i_r;
        end
        if (arr_v_r) begin
          pm1_nxt  = prev_q;
          bp2_nxt  = bp1_r;
          bp1_nxt  = bprev_q;
          bprv_nxt = second_rd;
          if (arr_k_r != '0) begin
            row_we   = 1'b1;
            row_wa   = arr_k_r;
            row_wd   = cell_cost;
            last_nxt = cell_cost;
            left_nxt = cell_cost;
          end
        end
        if (row_end) begin
          // current becomes previous, previous becomes before previous
          rot_nxt   = (rot_r == 2'd0) ? 2'd2 : (rot_r - 2'd1);
          aprv_nxt  = first_rd;
          k_nxt     = '0;
          arr_v_nxt = 1'b0;
          if (i_r == len1_r) begin
            st_nxt = ST_DONE;
          end else begin
            i_nxt = i_r + CW'(1);
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          odist_nxt   = dist_ext[DW-1:0];
          oovf_nxt    = ovf_r;
          len1_nxt    = '0;
          len2_nxt    = '0;
          ovf_nxt     = 1'b0;
          st_nxt      = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      k_r       <= '0;
      arr_v_r   <= 1'b0;
      arr_k_r   <= '0;
      i_r       <= '0;
      rot_r     <= 2'd0;
      len1_r    <= '0;
      len2_r    <= '0;
      ovf_r     <= 1'b0;
      mode_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      k_r       <= k_nxt;
      arr_v_r   <= arr_v_nxt;
      arr_k_r   <= arr_k_nxt;
      i_r       <= i_nxt;
      rot_r     <= rot_nxt;
      len1_r    <= len1_nxt;
      len2_r    <= len2_nxt;
      ovf_r     <= ovf_nxt;
      mode_r    <= mode_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    left_r  <= left_nxt;
    pm1_r   <= pm1_nxt;
    bp1_r   <= bp1_nxt;
    bp2_r   <= bp2_nxt;
    bprv_r  <= bprv_nxt;
    aprv_r  <= aprv_nxt;
    odist_r <= odist_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(8-DW){1'b0}}, odist_r};
  assign out_tuser  = oovf_r;

`ifndef SYNTHESIS
  // a compute word takes the engine busy on the next cycle
  a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd == edc_pkg::CMD_COMPUTE)) |=> !in_tready)
    else $error("engine still ready after compute word");

  // read pipeline never runs past the second word
  a_arrival_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    arr_v_r |-> (arr_k_r <= len2_r))
    else $error("cell column beyond second word length");

  // word lengths stay within capacity
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (len1_r <= CW'(MAX_LEN)) && (len2_r <= CW'(MAX_LEN)))
    else $error("word length beyond capacity");

  // distance is bounded by the longer word
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE) |-> ((last_r <= len1_r) || (last_r <= len2_r)))
    else $error("distance exceeds both word lengths");
`endif

endmodule

`default_nettype wire
